>>> sv/updown_pot_pulse_sequencer_unit_macros.svh
// Assertion macros for the up/down potentiometer pulse sequencer
`ifndef UPDOWN_POT_PULSE_SEQUENCER_UNIT_MACROS_SVH
`define UPDOWN_POT_PULSE_SEQUENCER_UNIT_MACROS_SVH

// expr must hold at every clock edge out of reset
`define UDPPS_ASSERT_ALWAYS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);

// cons must hold whenever ante holds
`define UDPPS_ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`endif

>>> sv/udpps_pkg.sv
// Shared constants and types for the up/down potentiometer pulse sequencer
package udpps_pkg;

	localparam int MAX_POSITION = 63;
	localparam int POS_W        = 6;
	localparam int TICK_W       = 16;
	localparam int TARGET_W     = 8;
	localparam int CFG_IDX_W    = 2;
	localparam int IN_DATA_W    = 8;
	localparam int OUT_DATA_W   = 16;

	typedef logic [POS_W-1:0]     pos_t;
	typedef logic [TICK_W-1:0]    tick_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	// highest reachable wiper position, limited by the position width
	localparam pos_t TOP_POSITION = (MAX_POSITION > 63) ? 6'd63 : POS_W'(MAX_POSITION);

	// register indexes
	localparam cfg_idx_t REG_SETUP = 2'd0;
	localparam cfg_idx_t REG_HALF  = 2'd1;
	localparam cfg_idx_t REG_HOLD  = 2'd2;

	// register reset values
	localparam tick_t SETUP_RST = 16'd5;
	localparam tick_t HALF_RST  = 16'd3;
	localparam tick_t HOLD_RST  = 16'd5;

	// input kinds
	localparam logic OP_TICK    = 1'b0;
	localparam logic OP_REQUEST = 1'b1;

endpackage

>>> sv/updown_pot_pulse_sequencer_unit.sv
// Up/down potentiometer pulse sequencer: input stage, sequencer state and result register
// The input register and then the result register lie between an accepted input beat and its result beat.
// Throughput: one beat per cycle while m_axis_tready keeps up; the whole state update is a single pass of small logic.
// The result register and the input register each hold one beat, so one further input beat
// is taken while a finished result waits on m_axis_tready, then s_axis_tready drops.
// Reset (arst_n low, asynchronous): idle, CS high, UD high, position 0, timing registers 5/3/5.
module updown_pot_pulse_sequencer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_axis_tvalid,
	output logic                               s_axis_tready,
	input  logic [udpps_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // [7:0] target
	input  logic                               s_axis_tuser,  // [0] op
	output logic                               m_axis_tvalid,
	input  logic                               m_axis_tready,
	// [0] cs_level, [1] ud_level, [2] busy_res, [3] rejected, [9:4] position, [15:10] zero
	output logic [udpps_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
	input  logic                               cfg_we,
	input  logic [udpps_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [udpps_pkg::TICK_W-1:0]       cfg_data
);
	import udpps_pkg::*;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SETUP,
		PH_HALF_A,
		PH_HALF_B,
		PH_HOLD
	} phase_t;

	// timing registers
	tick_t setup_q, half_q, hold_q;

	// input stage
	logic                valid_s1;
	logic                op_s1;
	logic [TARGET_W-1:0] target_s1;

	// sequencer state
	phase_t phase_q, phase_d;
	pos_t   pos_q, pos_d;
	pos_t   pend_q, pend_d;
	tick_t  delay_q, delay_d;
	pos_t   pulses_q, pulses_d;
	logic   up_q, up_d;
	logic   cs_q, cs_d;
	logic   ud_q, ud_d;
	logic   rej_d;

	// result register
	logic                  out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	logic  advance;
	logic  done;
	tick_t delay_dec;
	pos_t  tgt;
	pos_t  pulses_dec;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;
	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;

	assign done       = (delay_q <= 16'd1);
	assign delay_dec  = delay_q - 16'd1;
	assign pulses_dec = pulses_q - 6'd1;
	assign tgt        = (target_s1 > TARGET_W'(TOP_POSITION)) ? TOP_POSITION
	                                                           : target_s1[POS_W-1:0];

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		pend_d   = pend_q;
		delay_d  = delay_q;
		pulses_d = pulses_q;
		up_d     = up_q;
		cs_d     = cs_q;
		ud_d     = ud_q;
		rej_d    = 1'b0;
		if (op_s1 == OP_REQUEST) begin
			if (phase_q != PH_IDLE) begin
				rej_d = 1'b1;
			end else if (tgt != pos_q) begin
				pend_d = tgt;
				if (tgt > pos_q) begin
					up_d     = 1'b1;
					pulses_d = tgt - pos_q;
				end else begin
					up_d     = 1'b0;
					pulses_d = pos_q - tgt;
				end
				ud_d    = (tgt > pos_q);
				cs_d    = 1'b0;
				delay_d = setup_q;
				phase_d = PH_SETUP;
			end
		end else begin
			case (phase_q)
				PH_IDLE: begin
				end
				PH_SETUP: begin
					if (done) begin
						ud_d    = ~up_q;
						delay_d = half_q;
						phase_d = PH_HALF_A;
					end else begin
						delay_d = delay_dec;
					end
				end
				PH_HALF_A: begin
					if (done) begin
						ud_d    = up_q;
						delay_d = half_q;
						phase_d = PH_HALF_B;
					end else begin
						delay_d = delay_dec;
					end
				end
				PH_HALF_B: begin
					if (done) begin
						pulses_d = pulses_dec;
						if (pulses_dec != '0) begin
							ud_d    = ~up_q;
							delay_d = half_q;
							phase_d = PH_HALF_A;
						end else begin
							pos_d   = pend_q;
							delay_d = hold_q;
							phase_d = PH_HOLD;
						end
					end else begin
						delay_d = delay_dec;
					end
				end
				PH_HOLD: begin
					if (done) begin
						delay_d = '0;
						ud_d    = 1'b1;
						cs_d    = 1'b1;
						phase_d = PH_IDLE;
					end else begin
						delay_d = delay_dec;
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			setup_q     <= SETUP_RST;
			half_q      <= HALF_RST;
			hold_q      <= HOLD_RST;
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
			phase_q     <= PH_IDLE;
			pos_q       <= '0;
			pend_q      <= '0;
			delay_q     <= '0;
			pulses_q    <= '0;
			up_q        <= 1'b0;
			cs_q        <= 1'b1;
			ud_q        <= 1'b1;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SETUP: setup_q <= cfg_data;
					REG_HALF:  half_q  <= cfg_data;
					REG_HOLD:  hold_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (s_axis_tready) begin
				valid_s1 <= s_axis_tvalid;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
				phase_q     <= phase_d;
				pos_q       <= pos_d;
				pend_q      <= pend_d;
				delay_q     <= delay_d;
				pulses_q    <= pulses_d;
				up_q        <= up_d;
				cs_q        <= cs_d;
				ud_q        <= ud_d;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			op_s1     <= s_axis_tuser;
			target_s1 <= s_axis_tdata;
		end
		if (advance) begin
			out_data_q <= {6'd0, pos_d, rej_d, (phase_d != PH_IDLE), ud_d, cs_d};
		end
	end

`include "updown_pot_pulse_sequencer_unit_macros.svh"

	`UDPPS_ASSERT_IMPLIES(a_idle_pins, phase_q == PH_IDLE, cs_q && ud_q, "idle, pins held")
	`UDPPS_ASSERT_ALWAYS(a_cs_busy, (phase_q != PH_IDLE) == !cs_q, "cs out of step")
	`UDPPS_ASSERT_IMPLIES(a_pulses_left, phase_q == PH_HALF_A || phase_q == PH_HALF_B, pulses_q != '0, "no pulses")
	`UDPPS_ASSERT_IMPLIES(a_reject_busy, out_valid_q && out_data_q[3], out_data_q[2], "reject not busy")

endmodule

>>> test/updown_pot_pulse_sequencer_unit_tb.sv
// Testbench for the up/down potentiometer pulse sequencer: random stream traffic vs a predictor
module updown_pot_pulse_sequencer_unit_tb;
	import udpps_pkg::*;

	localparam int CYCLE_LIMIT = 1500000;
	localparam cfg_idx_t REG_NONE = 2'd3;
	localparam tick_t TICK_MAX = 16'hFFFF;

	typedef enum logic [2:0] {SEQ_IDLE, SEQ_SETUP, SEQ_UD_LEAVE, SEQ_UD_BACK, SEQ_HOLD} seq_phase_t;

	typedef struct {
		logic       op;
		logic [7:0] target;
	} pot_cmd_t;

	// packed to match m_axis_tdata[9:0]
	typedef struct packed {
		pos_t position;
		logic rejected;
		logic busy;
		logic ud;
		logic cs;
	} pot_pins_t;

	logic clk;
	logic arst_n = 1'b0;
	logic s_axis_tvalid = 1'b0;
	logic s_axis_tready;
	logic [IN_DATA_W-1:0] s_axis_tdata = '0;
	logic s_axis_tuser = OP_TICK;
	logic m_axis_tvalid;
	logic m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic cfg_we = 1'b0;
	cfg_idx_t cfg_index = REG_SETUP;
	tick_t cfg_data = '0;

	pot_cmd_t queued_cmds[$];
	pot_pins_t due_pins[$];
	pot_cmd_t shown;
	pot_pins_t got_pins;
	pot_pins_t want_pins;
	int pin_errs = 0;
	int cycles = 0;
	logic calm;

	// predictor copy of the block
	tick_t setup_len = SETUP_RST;
	tick_t half_len = HALF_RST;
	tick_t hold_len = HOLD_RST;
	seq_phase_t seq_phase = SEQ_IDLE;
	pos_t wiper = '0;
	pos_t goal = '0;
	pos_t pulses = '0;
	tick_t dly = '0;
	logic going_up = 1'b0;
	logic cs_pin = 1'b1;
	logic ud_pin = 1'b1;

	updown_pot_pulse_sequencer_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	assign calm = (cycles >= 300) && (cycles < 700);

	function automatic logic wait_elapsed();
		if (dly <= 1) begin
			dly = '0;
			return 1'b1;
		end
		dly = dly - 1'b1;
		return 1'b0;
	endfunction

	function automatic void open_pulse();
		ud_pin = ~going_up;
		dly = half_len;
		seq_phase = SEQ_UD_LEAVE;
	endfunction

	function automatic pot_pins_t step_pot(logic op, logic [7:0] target);
		pot_pins_t r;
		pos_t aim;
		logic rej;
		rej = 1'b0;
		if (op == OP_REQUEST) begin
			if (seq_phase != SEQ_IDLE) begin
				rej = 1'b1;
			end else begin
				aim = (target > TOP_POSITION) ? TOP_POSITION : target[POS_W-1:0];
				if (aim != wiper) begin
					goal = aim;
					going_up = aim > wiper;
					pulses = going_up ? aim - wiper : wiper - aim;
					ud_pin = going_up;
					cs_pin = 1'b0;
					dly = setup_len;
					seq_phase = SEQ_SETUP;
				end
			end
		end else begin
			case (seq_phase)
				SEQ_SETUP: begin
					if (wait_elapsed())
						open_pulse();
				end
				SEQ_UD_LEAVE: begin
					if (wait_elapsed()) begin
						ud_pin = going_up;
						dly = half_len;
						seq_phase = SEQ_UD_BACK;
					end
				end
				SEQ_UD_BACK: begin
					if (wait_elapsed()) begin
						pulses = pulses - 1'b1;
						if (pulses != 0) begin
							open_pulse();
						end else begin
							wiper = goal;
							dly = hold_len;
							seq_phase = SEQ_HOLD;
						end
					end
				end
				SEQ_HOLD: begin
					if (wait_elapsed()) begin
						ud_pin = 1'b1;
						cs_pin = 1'b1;
						seq_phase = SEQ_IDLE;
					end
				end
				default: seq_phase = SEQ_IDLE;
			endcase
		end
		r.cs = cs_pin;
		r.ud = ud_pin;
		r.busy = seq_phase != SEQ_IDLE;
		r.rejected = rej;
		r.position = wiper;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
		end else begin
			if (s_axis_tvalid && s_axis_tready)
				due_pins.push_back(step_pot(shown.op, shown.target));
			if (!s_axis_tvalid || s_axis_tready) begin
				if (queued_cmds.size() > 0 && (calm || $urandom_range(0, 99) >= 6)) begin
					shown = queued_cmds.pop_front();
					s_axis_tvalid <= 1'b1;
					s_axis_tdata <= shown.target;
					s_axis_tuser <= shown.op;
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got_pins = pot_pins_t'(m_axis_tdata[9:0]);
				if (due_pins.size() == 0) begin
					pin_errs++;
					if (pin_errs <= 10)
						$display("unexpected beat: tdata %h", m_axis_tdata);
				end else begin
					want_pins = due_pins.pop_front();
					if (got_pins !== want_pins || m_axis_tdata[15:10] !== '0) begin
						pin_errs++;
						if (pin_errs <= 10) begin
							$write("mismatch (exp/act): cs %b/%b ud %b/%b busy %b/%b ",
								want_pins.cs, got_pins.cs, want_pins.ud, got_pins.ud,
								want_pins.busy, got_pins.busy);
							$display("rej %b/%b pos %0d/%0d pad %h",
								want_pins.rejected, got_pins.rejected,
								want_pins.position, got_pins.position,
								m_axis_tdata[15:10]);
						end
					end
				end
			end
			m_axis_tready <= calm || ($urandom_range(0, 99) >= 6);
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic push_cmd(input logic op, input logic [7:0] target);
		pot_cmd_t c;
		c.op = op;
		c.target = target;
		queued_cmds.push_back(c);
	endtask

	task automatic push_ticks(input int n);
		for (int i = 0; i < n; i++)
			push_cmd(OP_TICK, 8'($urandom_range(0, 255)));
	endtask

	task automatic write_reg(input cfg_idx_t idx, input tick_t val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		case (idx)
			REG_SETUP: setup_len = val;
			REG_HALF: half_len = val;
			REG_HOLD: hold_len = val;
			default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic write_timing(input tick_t su, input tick_t hp, input tick_t ho);
		write_reg(REG_SETUP, su);
		write_reg(REG_HALF, hp);
		write_reg(REG_HOLD, ho);
	endtask

	task automatic drain();
		while (queued_cmds.size() != 0 || s_axis_tvalid || due_pins.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic queue_mix(input int n, input int req_pct);
		int pick;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 99) < req_pct) begin
				pick = $urandom_range(0, 9);
				if (pick < 6)
					push_cmd(OP_REQUEST, 8'($urandom_range(0, 63)));
				else if (pick < 8)
					push_cmd(OP_REQUEST, 8'($urandom_range(64, 255)));
				else
					push_cmd(OP_REQUEST, 8'($urandom_range(0, 3)));
			end else begin
				push_ticks(1);
			end
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset timing: idle tick, request for current position, one step up, busy request
		push_ticks(1);
		push_cmd(OP_REQUEST, 8'd0);
		push_cmd(OP_REQUEST, 8'd1);
		push_cmd(OP_REQUEST, 8'd40);
		push_ticks(17);
		drain();

		// zero registers act as one; index 3 is not a register
		write_timing('0, '0, '0);
		write_reg(REG_NONE, TICK_MAX);
		push_cmd(OP_REQUEST, 8'hFF);
		push_ticks(130);
		push_cmd(OP_REQUEST, 8'd63);
		push_cmd(OP_REQUEST, 8'd0);
		push_ticks(130);
		drain();

		write_timing(16'd1, 16'd1, 16'd1);
		queue_mix(150, 15);
		drain();

		write_timing(16'($urandom_range(1, 6)), 16'($urandom_range(1, 6)),
			16'($urandom_range(1, 6)));
		queue_mix(150, 12);
		drain();

		// timing changes land while a sequence may still be running
		for (int k = 0; k < 5; k++) begin
			write_timing(16'($urandom_range(1, 8)), 16'($urandom_range(1, 8)),
				16'($urandom_range(1, 8)));
			queue_mix(60, 15);
			drain();
		end

		// finish any open sequence on short timing, then start one on the longest
		write_timing(16'd1, 16'd1, 16'd1);
		while (seq_phase != SEQ_IDLE) begin
			push_ticks(16);
			drain();
		end
		write_timing(TICK_MAX, TICK_MAX, TICK_MAX);
		push_cmd(OP_REQUEST, (wiper < TOP_POSITION) ? 8'(wiper + 1) : 8'(wiper - 1));
		queue_mix(24, 25);
		drain();

		repeat (8) @(posedge clk);
		if (pin_errs == 0 && due_pins.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

>>> updown_pot_pulse_sequencer_unit.f
+incdir+sv
sv/udpps_pkg.sv
sv/updown_pot_pulse_sequencer_unit.sv
test/updown_pot_pulse_sequencer_unit_tb.sv
